// ===== src/golay_dec_pkg.sv =====
// ----------------------------------------------------------------------------
// golay_dec_pkg
// Shared types, constants and helper functions for the (23,12) Golay
// error trapping decoder.
// ----------------------------------------------------------------------------
package golay_dec_pkg;

    localparam int unsigned CODE_LEN = 23;
    localparam int unsigned SYN_W    = 11;
    localparam int unsigned WORD_W   = 24;
    localparam int unsigned CNT_W    = $clog2(CODE_LEN);

    // g(x) = 1+x^2+x^4+x^5+x^6+x^10+x^11, without the x^11 term
    localparam logic [SYN_W-1:0] GEN_TAPS = 11'h475;
    localparam logic [SYN_W-1:0] SYN_X16  = 11'h366;
    localparam logic [SYN_W-1:0] SYN_X17  = 11'h6CC;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CODE_LEN - 1);

    // positions that the trap tests refer to, before rotation by the shift
    localparam int unsigned PAT_BASE = 12;
    localparam int unsigned FLIP_X16 = 6;
    localparam int unsigned FLIP_X17 = 5;

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_SHIFT_IN = 4'b0010,
        S_TRAP     = 4'b0100,
        S_CORRECT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;
        logic shift_in;
        logic trap;
        logic correct;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_last;
        logic hit;
        logic out_blocked;
    } t_dp_status;

    function automatic logic [3:0] weight11(input logic [SYN_W-1:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < SYN_W; i++) begin
            n = n + 4'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [SYN_W-1:0] syn_shift(input logic [SYN_W-1:0] s,
                                                   input logic in_bit);
        logic [SYN_W-1:0] r;
        r = {s[SYN_W-2:0], 1'b0};
        if (s[SYN_W-1]) begin
            r = r ^ GEN_TAPS;
        end
        r[0] = r[0] ^ in_bit;
        return r;
    endfunction

endpackage

// ===== src/golay_dec_ctrl.sv =====
// ----------------------------------------------------------------------------
// golay_dec_ctrl
// Sequencer for the decoder: load, serial syndrome build, trapping search,
// correction and hand-off to the output register.
// ----------------------------------------------------------------------------
module golay_dec_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_busy,
    input  golay_dec_pkg::t_dp_status i_status,
    output golay_dec_pkg::t_dp_cmd    o_cmd
);

    golay_dec_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= golay_dec_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            golay_dec_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = golay_dec_pkg::S_SHIFT_IN;
                end
            end
            golay_dec_pkg::S_SHIFT_IN: begin
                o_cmd.shift_in = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = golay_dec_pkg::S_TRAP;
                end
            end
            golay_dec_pkg::S_TRAP: begin
                o_cmd.trap = 1'b1;
                if (i_status.hit || i_status.cnt_last) begin
                    n_state = golay_dec_pkg::S_CORRECT;
                end
            end
            golay_dec_pkg::S_CORRECT: begin
                // hold until the output register can take the result
                if (!i_status.out_blocked) begin
                    o_cmd.correct = 1'b1;
                    n_state       = golay_dec_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = golay_dec_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != golay_dec_pkg::S_IDLE);

endmodule

// ===== src/golay_dec_dp.sv =====
// ----------------------------------------------------------------------------
// golay_dec_dp
// Datapath: word and syndrome registers, shift counter, trap tests,
// rotating correction and the output register.
// ----------------------------------------------------------------------------
module golay_dec_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  golay_dec_pkg::t_dp_cmd    i_cmd,
    output golay_dec_pkg::t_dp_status o_status,
    input  logic [golay_dec_pkg::WORD_W-1:0] i_received_word,
    input  logic                      i_stall,
    output logic                      o_valid,
    output logic [golay_dec_pkg::WORD_W-1:0] o_decoded_word,
    output logic                      o_trap_failed
);

    localparam int unsigned N  = golay_dec_pkg::CODE_LEN;
    localparam int unsigned SW = golay_dec_pkg::SYN_W;

    logic [N-1:0]                    r_word;
    logic [SW-1:0]                   r_syn;
    logic [golay_dec_pkg::CNT_W-1:0] r_cnt;
    logic [N-1:0]                    r_err;
    logic                            r_failed;
    logic                            r_out_valid;
    logic [golay_dec_pkg::WORD_W-1:0] r_out_word;
    logic                            r_out_failed;

    logic            cnt_last;
    logic            hit0, hit16, hit17, hit;
    logic [SW-1:0]   t16, t17, pattern;
    logic [N-1:0]    err_base;
    logic [2*N-1:0]  err_dbl;
    logic [N-1:0]    err_rot;
    logic [N-1:0]    corrected;

    assign cnt_last = (r_cnt == golay_dec_pkg::CNT_LAST);

    // the three trap tests of one shift position
    always_comb begin
        t16   = r_syn ^ golay_dec_pkg::SYN_X16;
        t17   = r_syn ^ golay_dec_pkg::SYN_X17;
        hit0  = (golay_dec_pkg::weight11(r_syn) <= 4'd3);
        hit16 = !hit0 && (golay_dec_pkg::weight11(t16) <= 4'd2);
        hit17 = !hit0 && !hit16 && (golay_dec_pkg::weight11(t17) <= 4'd2);
        hit   = hit0 || hit16 || hit17;
        if (hit0) begin
            pattern = r_syn;
        end else if (hit16) begin
            pattern = t16;
        end else begin
            pattern = t17;
        end
        err_base = '0;
        for (int m = 0; m < SW; m++) begin
            err_base[golay_dec_pkg::PAT_BASE + m] = pattern[SW-1-m];
        end
        err_base[golay_dec_pkg::FLIP_X16] = err_base[golay_dec_pkg::FLIP_X16] ^ hit16;
        err_base[golay_dec_pkg::FLIP_X17] = err_base[golay_dec_pkg::FLIP_X17] ^ hit17;
        if (!hit) begin
            err_base = '0;
        end
    end

    // rotate the error vector left by the shift count, modulo the code length
    always_comb begin
        err_dbl   = {r_err, r_err} << r_cnt;
        err_rot   = err_dbl[2*N-1:N];
        corrected = r_word ^ err_rot;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= i_received_word[N-1:0];
            r_syn  <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.shift_in) begin
            r_syn <= golay_dec_pkg::syn_shift(r_syn, r_word[r_cnt]);
            r_cnt <= cnt_last ? '0 : r_cnt + 1'b1;
        end else if (i_cmd.trap) begin
            r_err    <= err_base;
            r_failed <= !hit;
            if (!hit && !cnt_last) begin
                r_syn <= golay_dec_pkg::syn_shift(r_syn, 1'b0);
                r_cnt <= r_cnt + 1'b1;
            end
        end
        if (i_cmd.correct) begin
            r_out_word   <= {^corrected, corrected};
            r_out_failed <= r_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.correct) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.cnt_last    = cnt_last;
    assign o_status.hit         = hit;
    assign o_status.out_blocked = r_out_valid && i_stall;

    assign o_valid        = r_out_valid;
    assign o_decoded_word = r_out_word;
    assign o_trap_failed  = r_out_failed;

endmodule

// ===== src/golay_23_12_error_trap_decoder_top.sv =====
// steps: a load, the serial syndrome build over all code bits, the trap search
// (ends on a hit or at the last shift) and the correction, held by i_stall
// requests: one at a time, set by the single shared syndrome register; a new
// request is taken only when the sequencer is back in idle
// reset: synchronous active-low i_rst_n returns the sequencer to idle
// and empties the output register
// ----------------------------------------------------------------------------
// golay_23_12_error_trap_decoder_top
// (23,12) Golay decoder using serial syndrome build and error trapping,
// with an output register between the decoder and the result channel.
// ----------------------------------------------------------------------------
module golay_23_12_error_trap_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [23:0] i_received_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [23:0] o_decoded_word,
    output logic        o_trap_failed
);

    golay_dec_pkg::t_dp_cmd    cmd;
    golay_dec_pkg::t_dp_status status;
    logic                      busy;

    golay_dec_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_busy   (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    golay_dec_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_received_word (i_received_word),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_decoded_word  (o_decoded_word),
        .o_trap_failed   (o_trap_failed)
    );

    assign o_stall = busy;

    // an accepted request keeps the decoder busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("decoder not busy after request accept");

    // a correction always lands in the output register
    a_correct_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.correct |=> o_valid)
        else $error("correction did not produce a result");

    // the parity bit of every result is the even parity of the code bits
    a_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_decoded_word[23] == ^o_decoded_word[22:0]))
        else $error("result parity bit wrong");

endmodule
